// File: rtl/fir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_pkg - shared types and constants for the 31-tap low-pass FIR
// Tap count, coefficient table and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int TAPS      = 31;
	localparam int TAP_IDX_W = 5;
	localparam int COEF_W    = 12;
	localparam int FRAC_BITS = 16;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                 shift_en;   // push the new sample into the delay line
		logic                 clear_acc;  // zero the accumulator
		logic                 mul_en;     // register one tap product
		logic [TAP_IDX_W-1:0] tap;        // tap taken by the multiplier
		logic                 acc_en;     // add the registered product
		logic                 load_out;   // round, saturate and load the result
	} fir_cmd_t;

	// Symmetric unsigned Q0.16 coefficients
	function automatic logic [COEF_W-1:0] coef_lookup(input logic [TAP_IDX_W-1:0] idx);
		logic [COEF_W-1:0] c;
		unique case (idx)
			5'd0,  5'd30: c = 12'd1258;
			5'd1,  5'd29: c = 12'd1353;
			5'd2,  5'd28: c = 12'd1453;
			5'd3,  5'd27: c = 12'd1558;
			5'd4,  5'd26: c = 12'd1668;
			5'd5,  5'd25: c = 12'd1784;
			5'd6,  5'd24: c = 12'd1904;
			5'd7,  5'd23: c = 12'd2030;
			5'd8,  5'd22: c = 12'd2161;
			5'd9,  5'd21: c = 12'd2298;
			5'd10, 5'd20: c = 12'd2440;
			5'd11, 5'd19: c = 12'd2587;
			5'd12, 5'd18: c = 12'd2740;
			5'd13, 5'd17: c = 12'd2899;
			5'd14, 5'd16: c = 12'd3063;
			5'd15:        c = 12'd3146;
			default:      c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/fir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_ctrl - sequencer for the shared multiply-accumulate
// Accepts a request, walks the taps one per cycle and hands the result to the
// output register once that register is free.
// ----------------------------------------------------------------------------
module fir_ctrl
	import fir_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	output logic     filtered_valid,
	input  logic     filtered_stall,
	output fir_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_LAST,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [TAP_IDX_W-1:0] tap_q;
	logic                 out_valid_q;
	logic                 in_take;
	logic                 out_take;
	logic                 out_free;

	localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAPS - 1);

	// Handshake qualifiers
	assign sample_stall   = (state_q != ST_IDLE);
	assign in_take        = sample_valid && !sample_stall;
	assign out_take       = out_valid_q && !filtered_stall;
	assign out_free       = !out_valid_q || !filtered_stall;
	assign filtered_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.tap       = tap_q;
		cmd.shift_en  = in_take;
		cmd.clear_acc = in_take;
		cmd.mul_en    = (state_q == ST_MAC);
		cmd.acc_en    = ((state_q == ST_MAC) && (tap_q != '0)) || (state_q == ST_LAST);
		cmd.load_out  = (state_q == ST_OUT) && out_free;
	end

	// Advance state, tap counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_take)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (in_take)
						state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (tap_q == LAST_TAP) begin
						state_q <= ST_LAST;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/fir_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_dp - delay line, shared multiply-accumulate and output stage
// One tap product per cycle, registered, then accumulated; the sum is
// rounded half up to sample scale and saturated into the output register.
// ----------------------------------------------------------------------------
module fir_dp
	import fir_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fir_cmd_t                      cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] filtered
);

	localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
	localparam int ACC_W  = SAMPLE_BITS + 18;
	localparam int Y_W    = ACC_W - FRAC_BITS;

	localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [Y_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

	logic signed [SAMPLE_BITS-1:0] hist_q [TAPS];
	logic signed [PROD_W-1:0]      prod_s1;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic signed [COEF_W:0]   coef_s;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [Y_W-1:0]    y_full;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// Delay line, newest sample at entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				hist_q[i] <= '0;
		end else if (cmd.shift_en) begin
			hist_q[0] <= sample;
			for (int i = 1; i < TAPS; i++)
				hist_q[i] <= hist_q[i-1];
		end
	end

	// Multiply one tap
	assign coef_s = $signed({1'b0, coef_lookup(cmd.tap)});

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_s1 <= PROD_W'(hist_q[cmd.tap] * coef_s);
	end

	// Accumulate
	assign prod_ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_ff @(posedge clk) begin
		if (cmd.clear_acc)
			acc_q <= '0;
		else if (cmd.acc_en)
			acc_q <= acc_q + prod_ext;
	end

	// Round half up and saturate
	always_comb begin
		acc_rnd = acc_q + RND_HALF;
		y_full  = acc_rnd[ACC_W-1:FRAC_BITS];
		if (y_full > SAT_HI)
			y_sat = SAT_HI[SAMPLE_BITS-1:0];
		else if (y_full < SAT_LO)
			y_sat = SAT_LO[SAMPLE_BITS-1:0];
		else
			y_sat = y_full[SAMPLE_BITS-1:0];
	end

	// Hold the result until the next load
	always_ff @(posedge clk) begin
		if (cmd.load_out)
			filtered_q <= y_sat;
	end

	assign filtered = filtered_q;

endmodule

// File: rtl/fir_lowpass_31tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lowpass_31tap - direct-form 31-tap low-pass FIR filter
// Fixed symmetric Q0.16 coefficients, result rounded and saturated.
// ----------------------------------------------------------------------------
//  channel   | valid          | stall          | payload
//  ----------+----------------+----------------+------------------------------
//  input     | sample_valid   | sample_stall   | sample   [SAMPLE_BITS] signed
//  output    | filtered_valid | filtered_stall | filtered [SAMPLE_BITS] signed
//
//  A request is accepted, then all 31 taps pass through the single shared
//  multiplier (one tap per cycle), then the final add; the output register
//  is loaded once free. The next request is accepted right after that load.
//  Reset clears the delay line to zero and empties the output register.
//  A stalled result holds in the output register; a finished sum waits for it.
// ----------------------------------------------------------------------------
module fir_lowpass_31tap
	import fir_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          filtered_valid,
	input  logic                          filtered_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered
);

	fir_cmd_t cmd;

	fir_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.cmd            (cmd)
	);

	fir_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (sample),
		.filtered (filtered)
	);

endmodule

// File: tb/tb_fir_lowpass_31tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_lowpass_31tap - self-checking bench for the 31-tap low-pass FIR
// Drives signed samples through the request channel with random gaps and
// stalls the result channel in random bursts. A scoreboard keeps its own
// delay line and coefficient table, works out each rounded and saturated
// output, and compares it with what the filter returns, in order.
// ----------------------------------------------------------------------------
module tb_fir_lowpass_31tap
	import fir_pkg::*;
;

	localparam int SAMPLE_BITS  = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_FROM    = 800;
	localparam int DRAIN_AT     = 450;
	localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 16'sh8000;

	// Q0.16 low-pass taps, symmetric about the centre tap
	localparam int COEF_Q16 [TAPS] = '{
		1258, 1353, 1453, 1558, 1668, 1784, 1904, 2030,
		2161, 2298, 2440, 2587, 2740, 2899, 3063, 3146,
		3063, 2899, 2740, 2587, 2440, 2298, 2161, 2030,
		1904, 1784, 1668, 1558, 1453, 1353, 1258
	};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Filter scoreboard: own delay line, queue of expected outputs
	class filter_scoreboard;
		sample_t delay_line [TAPS];
		sample_t expected_q [$];
		int      errors;
		int      noted;
		int      checked;
		int      clipped_hi;
		int      clipped_lo;

		function new();
			foreach (delay_line[i])
				delay_line[i] = '0;
			errors     = 0;
			noted      = 0;
			checked    = 0;
			clipped_hi = 0;
			clipped_lo = 0;
		endfunction

		// Shift in an accepted request and queue the filtered value it gives
		function void note_sample(sample_t s);
			longint acc;
			longint y;
			for (int i = TAPS - 1; i > 0; i--)
				delay_line[i] = delay_line[i-1];
			delay_line[0] = s;
			acc = 0;
			foreach (delay_line[i])
				acc += longint'(delay_line[i]) * longint'(COEF_Q16[i]);
			// round half up, then clamp to the sample range
			y = (acc + 64'sd32768) >>> 16;
			if (y > longint'(FULL_POS)) begin
				y = longint'(FULL_POS);
				clipped_hi++;
			end else if (y < longint'(FULL_NEG)) begin
				y = longint'(FULL_NEG);
				clipped_lo++;
			end
			expected_q.push_back(sample_t'(y));
			noted++;
		endfunction

		// Compare a returned output with the oldest expectation
		function void check_filtered(sample_t f);
			sample_t want;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected filtered output, expected none, actual %0d",
					$time, f);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (f !== want) begin
				$display("%0t ns: filtered mismatch, expected %0d, actual %0d",
					$time, want, f);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic    clk            = 1'b0;
	logic    arst_n         = 1'b0;
	logic    sample_valid   = 1'b0;
	logic    sample_stall;
	sample_t sample         = '0;
	logic    filtered_valid;
	logic    filtered_stall = 1'b0;
	sample_t filtered;

	bit               calm = 1'b0;
	int               n_fed;
	filter_scoreboard sb;

	fir_lowpass_31tap #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.filtered_valid(filtered_valid),
		.filtered_stall(filtered_stall),
		.filtered      (filtered)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && filtered_valid && !filtered_stall)
			sb.check_filtered(filtered);
	end

	// Stall the result side in random bursts until the calm stretch
	initial begin : result_stalls
		int n;
		forever begin
			n = $urandom_range(1, 13);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0)
				filtered_stall <= 1'b1;
			else
				filtered_stall <= 1'b0;
		end
	end

	// Present one request and hold it until accepted
	task automatic send_sample(input sample_t s);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		sb.note_sample(s);
		n_fed++;
	endtask

	// Hold off the sender until every expected output is back
	task automatic drain_outputs();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Send a constant run of the given length
	task automatic send_run(input sample_t level, input int len);
		for (int i = 0; i < len; i++)
			send_sample(level);
	endtask

	initial begin : stimulus
		sample_t directed [20];
		int      pick;
		int      len;
		bit      drained;
		sample_t s;

		directed = '{
			16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000,
			16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh7FFF,
			16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh4000,
			16'shC000, 16'sh7FFE, 16'sh8001, 16'sh0000, 16'sh0000
		};
		sb      = new();
		n_fed   = 0;
		drained = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: impulses, extremes and bit patterns
		foreach (directed[i])
			send_sample(directed[i]);
		drain_outputs();

		// Random: plain noise, mixed with full-scale runs that clip, full-scale swings and small values
		n_fed = 0;
		while (n_fed < RANDOM_ITEMS) begin
			calm = (n_fed >= CALM_FROM);
			if (!drained && n_fed >= DRAIN_AT) begin
				drain_outputs();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 4) begin
				s = sample_t'($urandom_range(0, 65535));
				send_sample(s);
			end else if (pick <= 6) begin
				send_run(pick == 5 ? FULL_POS : FULL_NEG, $urandom_range(31, 36));
			end else if (pick == 7) begin
				len = $urandom_range(8, 20);
				for (int i = 0; i < len; i++)
					send_sample(i[0] ? FULL_NEG : FULL_POS);
			end else begin
				len = $urandom_range(5, 15);
				for (int i = 0; i < len; i++) begin
					s = sample_t'($urandom_range(0, 6)) - sample_t'(3);
					send_sample(s);
				end
			end
		end
		sample_valid <= 1'b0;

		// Let the last outputs come back, then idle before finishing
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d requests, %0d outputs checked.", sb.noted, sb.checked);
		$display("Outputs clipped high: %0d, clipped low: %0d.",
			sb.clipped_hi, sb.clipped_lo);
		if (sb.errors == 0)
			$display("tb_fir_lowpass_31tap: done, clean");
		else
			$display("tb_fir_lowpass_31tap: done, errors");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d outputs still expected.", sb.pending());
		$display("tb_fir_lowpass_31tap: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/fir_pkg.sv
rtl/fir_ctrl.sv
rtl/fir_dp.sv
rtl/fir_lowpass_31tap.sv
tb/tb_fir_lowpass_31tap.sv
